// ===== rtl/pfde_pkg.sv =====
// Shared constants, types and helper functions of the Playfair digraph encryptor.
package pfde_pkg;

  localparam int MAX_KEY_LETTERS = 9;
  localparam int SIDE            = 5;
  localparam int CELLS           = SIDE * SIDE;
  localparam int LETTERS         = 26;
  localparam int CODE_I          = 8;
  localparam int CODE_J          = 9;
  localparam int CODE_X          = 23;

  localparam int CODE_W   = 5;
  localparam int RC_W     = 3;
  localparam int POS_W    = 2 * RC_W;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int KLEN_W   = 4;
  localparam int KEY_BITS = CODE_W * MAX_KEY_LETTERS;
  localparam int CFG_DATA_W = (KEY_BITS > CODE_W) ? KEY_BITS : CODE_W;
  localparam int CFG_IDX_W  = 2;
  // candidate index of the square build sweep: key letters, then the alphabet
  localparam int IDX_W    = $clog2(MAX_KEY_LETTERS + LETTERS);

  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LETTER  = 2'd2;

  localparam logic OP_LETTER = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CODE_W-1:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] cipher_first;
    logic [CODE_W-1:0] cipher_second;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
  } pair_t;

  // one write of the square build into both lookup tables
  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] slot;
    logic [CODE_W-1:0] letter;
    logic [RC_W-1:0]   row;
    logic [RC_W-1:0]   col;
  } sq_wr_t;

  typedef enum logic {
    KG_IDLE,
    KG_BUILD
  } kg_state_t;

  function automatic logic [CODE_W-1:0] fold(input logic [CODE_W-1:0] c);
    return (c == CODE_W'(CODE_J)) ? CODE_W'(CODE_I) : c;
  endfunction

  function automatic logic [RC_W-1:0] wrap_inc(input logic [RC_W-1:0] v);
    return (v == RC_W'(SIDE - 1)) ? '0 : v + RC_W'(1);
  endfunction

  // row * 5 + col
  function automatic logic [CELL_W-1:0] cell_addr(input logic [RC_W-1:0] row,
                                                  input logic [RC_W-1:0] col);
    logic [CELL_W-1:0] r;
    r = CELL_W'(row);
    return (r << 2) + r + CELL_W'(col);
  endfunction

endpackage

// ===== rtl/playfair_digraph_encryptor.sv =====
// Top level of the Playfair digraph encryptor.
//
//   port group   direction  handshake         payload
//   in_*         input      in_valid/ready    in_item_t: operation, letter
//   out_*        output     out_valid/ready   out_item_t: cipher_first, cipher_second
//   cfg_*        input      cfg_we            cfg_index, cfg_wdata
//
// One beat per cycle in while in_ready is high; a digraph completed by a beat passes
// through the queue slot and the two registered table reads before it leaves.
// After reset and after each register write the square is swept in, one candidate
// letter a cycle, over the key letters (capped at MAX_KEY_LETTERS) and then the
// alphabet, with in_ready low meanwhile.
// A stalled out_ready holds the lookup pipe; the 4-entry queue keeps in_ready up
// until it fills.
module playfair_digraph_encryptor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pfde_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pfde_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [pfde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfde_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                        busy;
  logic [pfde_pkg::CODE_W-1:0] pad_code;
  pfde_pkg::sq_wr_t            sq_wr;
  logic                        push_valid;
  logic                        push_ready;
  pfde_pkg::pair_t             push_data;
  logic                        q_valid;
  logic                        q_pop;
  pfde_pkg::pair_t             q_data;

  pfde_keygen u_keygen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .busy     (busy),
    .pad_code (pad_code),
    .sq_wr    (sq_wr)
  );

  pfde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .busy      (busy),
    .pad_code  (pad_code),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .push_data (push_data)
  );

  pfde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (q_valid),
    .pop_ready (q_pop),
    .pop_data  (q_data)
  );

  pfde_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_wr    (sq_wr),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/pfde_ram.sv =====
// Generic RAM: one write port, two registered read ports with read enable.
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/pfde_keygen.sv =====
// Configuration registers and the sequencer that rebuilds the key square.
module pfde_keygen (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pfde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfde_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               busy,
  output logic [pfde_pkg::CODE_W-1:0]        pad_code,
  output pfde_pkg::sq_wr_t                   sq_wr
);

  logic [pfde_pkg::KEY_BITS-1:0] key_r;
  logic [pfde_pkg::KLEN_W-1:0]   klen_r;
  logic [pfde_pkg::CODE_W-1:0]   pad_r;

  pfde_pkg::kg_state_t           state_r, state_nxt;
  logic [pfde_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [pfde_pkg::LETTERS-1:0]  used_r, used_nxt;
  logic [pfde_pkg::CELL_W-1:0]   fill_r, fill_nxt;
  logic [pfde_pkg::RC_W-1:0]     row_r, row_nxt;
  logic [pfde_pkg::RC_W-1:0]     col_r, col_nxt;

  logic                          cfg_hit;
  logic [pfde_pkg::IDX_W-1:0]    n_use;
  logic [pfde_pkg::IDX_W-1:0]    alpha;
  logic [pfde_pkg::CODE_W-1:0]   key_c;
  logic [pfde_pkg::CODE_W-1:0]   cand;
  logic                          in_range;
  logic                          seen;
  logic                          full;
  logic                          take;
  logic                          last;

  assign cfg_hit = cfg_we && (cfg_index == pfde_pkg::CFG_KEY_LETTERS ||
                              cfg_index == pfde_pkg::CFG_KEY_LENGTH ||
                              cfg_index == pfde_pkg::CFG_PAD_LETTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      klen_r <= '0;
      pad_r  <= pfde_pkg::CODE_W'(pfde_pkg::CODE_X);
    end else if (cfg_we) begin
      case (cfg_index)
        pfde_pkg::CFG_KEY_LETTERS: key_r  <= cfg_wdata[pfde_pkg::KEY_BITS-1:0];
        pfde_pkg::CFG_KEY_LENGTH:  klen_r <= cfg_wdata[pfde_pkg::KLEN_W-1:0];
        pfde_pkg::CFG_PAD_LETTER:  pad_r  <= cfg_wdata[pfde_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign pad_code = (pad_r >= pfde_pkg::CODE_W'(pfde_pkg::LETTERS)) ?
                    pfde_pkg::CODE_W'(pfde_pkg::CODE_X) : pfde_pkg::fold(pad_r);

  always_comb begin
    n_use = (klen_r > pfde_pkg::KLEN_W'(pfde_pkg::MAX_KEY_LETTERS)) ?
            pfde_pkg::IDX_W'(pfde_pkg::MAX_KEY_LETTERS) : pfde_pkg::IDX_W'(klen_r);
    key_c = '0;
    for (int k = 0; k < pfde_pkg::MAX_KEY_LETTERS; k++) begin
      if (idx_r == pfde_pkg::IDX_W'(k)) begin
        key_c = key_r[pfde_pkg::CODE_W*k +: pfde_pkg::CODE_W];
      end
    end
    alpha    = idx_r - n_use;
    cand     = pfde_pkg::fold((idx_r < n_use) ? key_c : alpha[pfde_pkg::CODE_W-1:0]);
    in_range = cand < pfde_pkg::CODE_W'(pfde_pkg::LETTERS);
    seen     = in_range ? used_r[cand] : 1'b1;
    full     = fill_r == pfde_pkg::CELL_W'(pfde_pkg::CELLS);
    take     = (state_r == pfde_pkg::KG_BUILD) && !seen && !full;
    last     = idx_r == n_use + pfde_pkg::IDX_W'(pfde_pkg::LETTERS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfde_pkg::KG_BUILD;
      idx_r   <= '0;
      used_r  <= '0;
      fill_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      used_r  <= used_nxt;
      fill_r  <= fill_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    fill_nxt  = fill_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (cfg_hit) begin
      // any register write restarts the sweep
      state_nxt = pfde_pkg::KG_BUILD;
      idx_nxt   = '0;
      used_nxt  = '0;
      fill_nxt  = '0;
      row_nxt   = '0;
      col_nxt   = '0;
    end else begin
      case (state_r)
        pfde_pkg::KG_IDLE: ;
        pfde_pkg::KG_BUILD: begin
          if (take) begin
            used_nxt[cand] = 1'b1;
            fill_nxt       = fill_r + pfde_pkg::CELL_W'(1);
            col_nxt        = pfde_pkg::wrap_inc(col_r);
            if (col_r == pfde_pkg::RC_W'(pfde_pkg::SIDE - 1)) begin
              row_nxt = row_r + pfde_pkg::RC_W'(1);
            end
          end
          idx_nxt = idx_r + pfde_pkg::IDX_W'(1);
          if (last) begin
            state_nxt = pfde_pkg::KG_IDLE;
          end
        end
        default: state_nxt = pfde_pkg::KG_IDLE;
      endcase
    end
  end

  assign busy         = state_r == pfde_pkg::KG_BUILD;
  assign sq_wr.valid  = take;
  assign sq_wr.slot   = fill_r;
  assign sq_wr.letter = cand;
  assign sq_wr.row    = row_r;
  assign sq_wr.col    = col_r;

endmodule

// ===== rtl/pfde_front.sv =====
// Front end: takes letter and flush beats, pairs letters and emits digraphs.
module pfde_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pfde_pkg::in_item_t           in_data,
  input  logic                         busy,
  input  logic [pfde_pkg::CODE_W-1:0]  pad_code,
  input  logic                         push_ready,
  output logic                         push_valid,
  output pfde_pkg::pair_t              push_data
);

  logic [pfde_pkg::CODE_W-1:0] held_r, held_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic                        accept;
  logic [pfde_pkg::CODE_W-1:0] c;

  assign in_ready = !busy && push_ready;
  assign accept   = in_valid && in_ready;
  assign c        = pfde_pkg::fold(in_data.letter);

  always_comb begin
    held_nxt         = held_r;
    held_valid_nxt   = held_valid_r;
    push_valid       = 1'b0;
    push_data.first  = held_r;
    push_data.second = pad_code;
    if (accept) begin
      if (in_data.operation == pfde_pkg::OP_FLUSH) begin
        if (held_valid_r) begin
          push_valid     = 1'b1;
          held_valid_nxt = 1'b0;
          held_nxt       = '0;
        end
      end else if (in_data.letter < pfde_pkg::CODE_W'(pfde_pkg::LETTERS)) begin
        if (!held_valid_r) begin
          held_nxt       = c;
          held_valid_nxt = 1'b1;
        end else if (c == held_r) begin
          // doubled letter: pad goes in, the new letter stays held
          push_valid = 1'b1;
        end else begin
          push_valid       = 1'b1;
          push_data.second = c;
          held_valid_nxt   = 1'b0;
          held_nxt         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

// ===== rtl/pfde_queue.sv =====
// Short digraph queue between the front end and the lookup pipeline.
module pfde_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pfde_pkg::pair_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pfde_pkg::pair_t pop_data
);

  pfde_pkg::pair_t            mem_r [pfde_pkg::QDEPTH];
  logic [pfde_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [pfde_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [pfde_pkg::QAW:0]     count_r, count_nxt;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = count_r != (pfde_pkg::QAW+1)'(pfde_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + pfde_pkg::QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + pfde_pkg::QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (pfde_pkg::QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (pfde_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/pfde_back.sv =====
// Back end: position lookup, pair rule and square lookup, two RAM stages.
module pfde_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pfde_pkg::sq_wr_t   sq_wr,
  input  logic               q_valid,
  input  pfde_pkg::pair_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pfde_pkg::out_item_t out_data
);

  logic                         v1_r, v1_nxt;
  logic                         v2_r, v2_nxt;
  logic                         adv;
  logic [pfde_pkg::POS_W-1:0]   pos_a, pos_b;
  logic [pfde_pkg::RC_W-1:0]    r1, c1, r2, c2;
  logic [pfde_pkg::CELL_W-1:0]  addr_a, addr_b;
  logic [pfde_pkg::CODE_W-1:0]  sq_a, sq_b;

  // whole pipe holds while the result beat waits
  assign adv   = !v2_r || out_ready;
  assign q_pop = adv && q_valid;

  pfde_ram #(
    .WIDTH(pfde_pkg::POS_W),
    .DEPTH(pfde_pkg::LETTERS)
  ) u_pos_ram (
    .clk      (clk),
    .wr_en    (sq_wr.valid),
    .wr_addr  (sq_wr.letter),
    .wr_data  ({sq_wr.row, sq_wr.col}),
    .rd_en    (adv),
    .rd_addr_a(q_data.first),
    .rd_addr_b(q_data.second),
    .rd_data_a(pos_a),
    .rd_data_b(pos_b)
  );

  always_comb begin
    r1 = pos_a[pfde_pkg::POS_W-1:pfde_pkg::RC_W];
    c1 = pos_a[pfde_pkg::RC_W-1:0];
    r2 = pos_b[pfde_pkg::POS_W-1:pfde_pkg::RC_W];
    c2 = pos_b[pfde_pkg::RC_W-1:0];
    if (r1 == r2) begin
      addr_a = pfde_pkg::cell_addr(r1, pfde_pkg::wrap_inc(c1));
      addr_b = pfde_pkg::cell_addr(r2, pfde_pkg::wrap_inc(c2));
    end else if (c1 == c2) begin
      addr_a = pfde_pkg::cell_addr(pfde_pkg::wrap_inc(r1), c1);
      addr_b = pfde_pkg::cell_addr(pfde_pkg::wrap_inc(r2), c2);
    end else begin
      addr_a = pfde_pkg::cell_addr(r1, c2);
      addr_b = pfde_pkg::cell_addr(r2, c1);
    end
  end

  pfde_ram #(
    .WIDTH(pfde_pkg::CODE_W),
    .DEPTH(pfde_pkg::CELLS)
  ) u_sq_ram (
    .clk      (clk),
    .wr_en    (sq_wr.valid),
    .wr_addr  (sq_wr.slot),
    .wr_data  (sq_wr.letter),
    .rd_en    (adv),
    .rd_addr_a(addr_a),
    .rd_addr_b(addr_b),
    .rd_data_a(sq_a),
    .rd_data_b(sq_b)
  );

  always_comb begin
    v1_nxt = adv ? q_valid : v1_r;
    v2_nxt = adv ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  assign out_valid              = v2_r;
  assign out_data.cipher_first  = sq_a;
  assign out_data.cipher_second = sq_b;

endmodule

// ===== bench/playfair_digraph_encryptor_tb.sv =====
// Self-checking bench for the Playfair digraph encryptor: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import pfde_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int RAND_PHASES     = 8;
  localparam int SETTLE          = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [CODE_W-1:0] letter;
    logic              typed;
    logic [CODE_W-1:0] e_first;
    logic [CODE_W-1:0] e_second;
  } dir_row_t;

  // reset square: abcde / fghik / lmnop / qrstu / vwxyz
  localparam int DIR_N = 20;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{OP_FLUSH,  5'd0,  1'b0, 5'd0,  5'd0},   // flush, nothing held
    '{OP_LETTER, 5'd0,  1'b0, 5'd0,  5'd0},
    '{OP_LETTER, 5'd25, 1'b1, 5'd4,  5'd21},  // a z corners
    '{OP_LETTER, 5'd31, 1'b0, 5'd0,  5'd0},   // out of range, dropped
    '{OP_LETTER, 5'd26, 1'b0, 5'd0,  5'd0},
    '{OP_LETTER, CODE_W'(CODE_J), 1'b0, 5'd0, 5'd0},
    '{OP_LETTER, CODE_W'(CODE_I), 1'b1, 5'd7,  5'd24},  // j then i: doubled, pad inserted
    '{OP_FLUSH,  5'd0,  1'b1, 5'd7,  5'd24},  // i still held
    '{OP_LETTER, CODE_W'(CODE_X), 1'b0, 5'd0, 5'd0},
    '{OP_FLUSH,  5'd31, 1'b1, 5'd24, 5'd24},  // x with pad x
    '{OP_LETTER, 5'd0,  1'b0, 5'd0,  5'd0},
    '{OP_LETTER, 5'd1,  1'b1, 5'd1,  5'd2},   // same row
    '{OP_LETTER, 5'd0,  1'b0, 5'd0,  5'd0},
    '{OP_LETTER, 5'd5,  1'b1, 5'd5,  5'd11},  // same column
    '{OP_LETTER, 5'd4,  1'b0, 5'd0,  5'd0},
    '{OP_LETTER, 5'd0,  1'b1, 5'd0,  5'd1},   // row wrap
    '{OP_LETTER, 5'd21, 1'b0, 5'd0,  5'd0},
    '{OP_LETTER, 5'd0,  1'b1, 5'd0,  5'd5},   // column wrap
    '{OP_FLUSH,  5'd0,  1'b0, 5'd0,  5'd0},
    '{OP_LETTER, 5'd17, 1'b0, 5'd0,  5'd0}    // r stays held across the rekey
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [CODE_W-1:0] sq_cell [CELLS];
  logic [POS_W-1:0]  where_is [LETTERS];
  logic [CODE_W-1:0] held_code;
  logic              held_on;
  logic [KEY_BITS-1:0] key_reg;
  logic [KLEN_W-1:0]   klen_reg;
  logic [CODE_W-1:0]   pad_reg;

  out_item_t pending_pairs [$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  bit        calm = 1'b0;

  playfair_digraph_encryptor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void build_square();
    logic [LETTERS-1:0] seen;
    int n;
    int fill;
    logic [CODE_W-1:0] c;
    seen = '0;
    fill = 0;
    n = (klen_reg > MAX_KEY_LETTERS) ? MAX_KEY_LETTERS : int'(klen_reg);
    for (int i = 0; i < n + LETTERS; i++) begin
      c = (i < n) ? key_reg[CODE_W*i +: CODE_W] : CODE_W'(i - n);
      if (c == CODE_W'(CODE_J)) c = CODE_W'(CODE_I);
      if (c < LETTERS && fill < CELLS && !seen[c]) begin
        seen[c] = 1'b1;
        sq_cell[fill] = c;
        where_is[c] = {RC_W'(fill / SIDE), RC_W'(fill % SIDE)};
        fill++;
      end
    end
    where_is[CODE_J] = where_is[CODE_I];
  endfunction

  function automatic out_item_t encipher_pair(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b);
    out_item_t res;
    int r1, c1, r2, c2, i1, i2;
    r1 = int'(where_is[a][POS_W-1:RC_W]) % SIDE;
    c1 = int'(where_is[a][RC_W-1:0]) % SIDE;
    r2 = int'(where_is[b][POS_W-1:RC_W]) % SIDE;
    c2 = int'(where_is[b][RC_W-1:0]) % SIDE;
    if (r1 == r2) begin
      i1 = r1 * SIDE + (c1 + 1) % SIDE;
      i2 = r2 * SIDE + (c2 + 1) % SIDE;
    end else if (c1 == c2) begin
      i1 = ((r1 + 1) % SIDE) * SIDE + c1;
      i2 = ((r2 + 1) % SIDE) * SIDE + c2;
    end else begin
      i1 = r1 * SIDE + c2;
      i2 = r2 * SIDE + c1;
    end
    res.cipher_first  = sq_cell[i1];
    res.cipher_second = sq_cell[i2];
    return res;
  endfunction

  // one beat into the predictor; returns 1 when a digraph comes out
  function automatic logic advance_cipher(input in_item_t it, output out_item_t res);
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] pad;
    res = '0;
    if (pad_reg >= LETTERS) pad = CODE_W'(CODE_X);
    else if (pad_reg == CODE_W'(CODE_J)) pad = CODE_W'(CODE_I);
    else pad = pad_reg;
    if (it.operation == OP_FLUSH) begin
      if (!held_on) return 1'b0;
      res = encipher_pair(held_code, pad);
      held_on = 1'b0;
      held_code = '0;
      return 1'b1;
    end
    if (it.letter >= LETTERS) return 1'b0;
    c = (it.letter == CODE_W'(CODE_J)) ? CODE_W'(CODE_I) : it.letter;
    if (!held_on) begin
      held_code = c;
      held_on = 1'b1;
      return 1'b0;
    end
    if (c == held_code) begin
      res = encipher_pair(held_code, pad);
      return 1'b1;
    end
    res = encipher_pair(held_code, c);
    held_on = 1'b0;
    held_code = '0;
    return 1'b1;
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.operation = OP_LETTER;
    it.letter = CODE_W'($urandom_range(0, LETTERS - 1));
    if (r < 8) begin
      it.operation = OP_FLUSH;
      it.letter = CODE_W'($urandom_range(0, 31));
    end else if (r < 14) begin
      it.letter = CODE_W'($urandom_range(LETTERS, 31));
    end else if (r < 32 && held_on) begin
      it.letter = (held_code == CODE_W'(CODE_I) && r[0]) ? CODE_W'(CODE_J) : held_code;
    end else if (r < 40) begin
      it.letter = (pad_reg < LETTERS) ? pad_reg : CODE_W'(CODE_X);
    end
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_key();
    logic [CFG_DATA_W-1:0] k;
    k = '0;
    for (int i = 0; i < MAX_KEY_LETTERS; i++)
      k[CODE_W*i +: CODE_W] = ($urandom_range(0, 9) == 0) ?
                              CODE_W'($urandom_range(LETTERS, 31)) :
                              CODE_W'($urandom_range(0, LETTERS - 1));
    return k;
  endfunction

  task automatic send_beat(input in_item_t it, input logic typed, input out_item_t typed_res);
    int gap;
    out_item_t res;
    logic got;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = advance_cipher(it, res);
    if (typed) pending_pairs.push_back(typed_res);
    else if (got) pending_pairs.push_back(res);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEY_LETTERS: key_reg  = val[KEY_BITS-1:0];
      CFG_KEY_LENGTH:  klen_reg = val[KLEN_W-1:0];
      CFG_PAD_LETTER:  pad_reg  = val[CODE_W-1:0];
      default: ;
    endcase
    if (idx != CFG_SPARE) build_square();
    // square sweep holds in_ready low
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input int quota);
    int done;
    in_item_t it;
    done = 0;
    while (done < quota) begin
      it = pick_item();
      if (!(it.operation == OP_LETTER && it.letter >= LETTERS)) done++;
      send_beat(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  // result side: random stall before each beat
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected digraph %0d %0d", out_data.cipher_first, out_data.cipher_second);
      end else begin
        want = pending_pairs.pop_front();
        if (out_data.cipher_first !== want.cipher_first ||
            out_data.cipher_second !== want.cipher_second) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("digraph mismatch: expected %0d %0d, got %0d %0d",
                     want.cipher_first, want.cipher_second,
                     out_data.cipher_first, out_data.cipher_second);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("playfair_digraph_encryptor test failed");
      $finish;
    end
  end

  initial begin
    out_item_t want;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    key_reg   = '0;
    klen_reg  = '0;
    pad_reg   = CODE_W'(CODE_X);
    held_code = '0;
    held_on   = 1'b0;
    build_square();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_N; k++) begin
      want.cipher_first  = DIR_TAB[k].e_first;
      want.cipher_second = DIR_TAB[k].e_second;
      send_beat(in_item_t'{DIR_TAB[k].operation, DIR_TAB[k].letter}, DIR_TAB[k].typed, want);
    end
    in_valid <= 1'b0;

    // full nine-letter key of distinct letters
    drain();
    cfg_write(CFG_KEY_LETTERS, {5'd23, 5'd4, 5'd17, 5'd8, 5'd5, 5'd24, 5'd0, 5'd11, 5'd15});
    cfg_write(CFG_KEY_LENGTH, CFG_DATA_W'(9));
    cfg_write(CFG_PAD_LETTER, CFG_DATA_W'(CODE_X));
    run_phase(ITEMS_PER_PHASE);

    // all-ones key: over-long length, every key code invalid, invalid pad
    drain();
    cfg_write(CFG_KEY_LETTERS, {CFG_DATA_W{1'b1}});
    cfg_write(CFG_KEY_LENGTH, CFG_DATA_W'(15));
    cfg_write(CFG_PAD_LETTER, CFG_DATA_W'(31));
    calm = 1'b1;
    run_phase(ITEMS_PER_PHASE);

    // key of j's folds to i, pad j reads as i
    drain();
    calm = 1'b0;
    cfg_write(CFG_KEY_LETTERS, {MAX_KEY_LETTERS{CODE_W'(CODE_J)}});
    cfg_write(CFG_KEY_LENGTH, CFG_DATA_W'(5));
    cfg_write(CFG_PAD_LETTER, CFG_DATA_W'(CODE_J));
    run_phase(ITEMS_PER_PHASE);

    // empty key, pad a, and a write to the unused index
    drain();
    cfg_write(CFG_KEY_LETTERS, '0);
    cfg_write(CFG_KEY_LENGTH, '0);
    cfg_write(CFG_PAD_LETTER, '0);
    cfg_write(CFG_SPARE, random_key());
    run_phase(ITEMS_PER_PHASE);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      cfg_write(CFG_KEY_LETTERS, random_key());
      cfg_write(CFG_KEY_LENGTH, CFG_DATA_W'($urandom_range(0, 15)));
      cfg_write(CFG_PAD_LETTER, CFG_DATA_W'((p == 3) ? 25 : $urandom_range(0, 31)));
      calm = (p % 4 == 2);
      run_phase(ITEMS_PER_PHASE);
    end

    drain();
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("playfair_digraph_encryptor test passed");
    end else begin
      $display("playfair_digraph_encryptor test failed");
    end
    $finish;
  end

endmodule
